// File: rtl/bbcd_pkg.sv
// ----------------------------------------------------------------------------
// bbcd_pkg
// Shared types and codes of the buffer cache directory: command, status and
// sequencer state codes, the request and response items, and one entry's layout.
// ----------------------------------------------------------------------------
`default_nettype none

package bbcd_pkg;

   // Command codes carried by a request item.
   typedef enum logic [1:0] {
      CMD_GET     = 2'd0,
      CMD_RELEASE = 2'd1,
      CMD_PIN     = 2'd2,
      CMD_UNPIN   = 2'd3
   } cmd_type;

   // Status codes returned with each response item.
   typedef enum logic [1:0] {
      STAT_DONE      = 2'd0,
      STAT_NO_FREE   = 2'd1,
      STAT_COUNT_ERR = 2'd2
   } status_type;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE  = 2'd0,
      ST_SCAN  = 2'd1,
      ST_WRITE = 2'd2,
      ST_EXAM  = 2'd3
   } seq_state_type;

   localparam int unsigned COUNT_W = 8;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   // One request item.
   typedef struct packed {
      cmd_type     command;
      logic [7:0]  device_number;
      logic [31:0] block_number;
      logic [4:0]  entry_index;
      logic [31:0] time_now;
   } req_type;

   // One response item.
   typedef struct packed {
      status_type status;
      logic       hit;
      logic [4:0] found_entry;
      logic       need_read;
   } rsp_type;

   // One directory entry as it is stored in memory.
   typedef struct packed {
      logic               in_use;
      logic [7:0]         device;
      logic [31:0]        block;
      logic               data_valid;
      logic [COUNT_W-1:0] ref_count;
      logic [31:0]        stamp;
   } entry_type;

   localparam int unsigned ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

// File: rtl/block_buffer_cache_directory.sv
// ----------------------------------------------------------------------------
// block_buffer_cache_directory
// Directory of a disk-block buffer cache with least-recently-released
// replacement, held in one synchronous memory of ENTRIES entries.
// ----------------------------------------------------------------------------
// A get walks the whole directory memory, one entry per cycle through its
// single read port, and then writes the chosen entry back: busy stays high
// after the accept until that write-back is done. Release, pin and unpin read
// one entry and write it back unless its count would leave its range; one
// naming an entry beyond the directory never raises busy. Every item yields
// one result, shown for one cycle with rsp_strobe in the cycle after its work
// ends; that is the same cycle in which the next item may be started. The
// receiver cannot stall: it must take each result in the cycle it is strobed.
// State after reset is an empty directory and needs no clearing pass.
`default_nettype none

module block_buffer_cache_directory #(
   parameter int unsigned ENTRIES = 32
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   output      logic              busy,
   input  wire bbcd_pkg::req_type req_data,
   output      logic              rsp_strobe,
   output      bbcd_pkg::rsp_type rsp_data
);

   import bbcd_pkg::*;

   localparam int unsigned IDX_W = $clog2(ENTRIES);

   logic               mem_we;
   logic [IDX_W-1:0]   mem_waddr;
   logic [ENTRY_W-1:0] mem_wdata;
   logic               mem_re;
   logic [IDX_W-1:0]   mem_raddr;
   logic [ENTRY_W-1:0] mem_rdata;

   // Command sequencer.
   bbcd_seq #(
      .ENTRIES (ENTRIES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .mem_we     (mem_we),
      .mem_waddr  (mem_waddr),
      .mem_wdata  (mem_wdata),
      .mem_re     (mem_re),
      .mem_raddr  (mem_raddr),
      .mem_rdata  (mem_rdata)
   );

   // Directory memory, one entry per word.
   bbcd_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (ENTRIES)
   ) u_dir_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

endmodule

`default_nettype wire

// File: rtl/bbcd_ram.sv
// ----------------------------------------------------------------------------
// bbcd_ram
// Generic single-port-write, single-port-read memory with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module bbcd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/bbcd_seq.sv
// ----------------------------------------------------------------------------
// bbcd_seq
// Command sequencer: scans the directory memory one entry per cycle for a get,
// or reads one named entry for release, pin and unpin, then writes back.
// ----------------------------------------------------------------------------
`default_nettype none

module bbcd_seq #(
   parameter int unsigned ENTRIES = 32
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   output      logic                       busy,
   input  wire bbcd_pkg::req_type          req_data,
   output      logic                       rsp_strobe,
   output      bbcd_pkg::rsp_type          rsp_data,
   output      logic                       mem_we,
   output      logic [$clog2(ENTRIES)-1:0] mem_waddr,
   output      logic [bbcd_pkg::ENTRY_W-1:0] mem_wdata,
   output      logic                       mem_re,
   output      logic [$clog2(ENTRIES)-1:0] mem_raddr,
   input  wire logic [bbcd_pkg::ENTRY_W-1:0] mem_rdata
);

   import bbcd_pkg::*;

   localparam int unsigned IDX_W = $clog2(ENTRIES);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

   seq_state_type    state_ff, state_in;
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   req_type          req_ff, req_in;
   logic [ENTRIES-1:0] valid_ff, valid_in;
   logic             hit_found_ff, hit_found_in;
   logic [IDX_W-1:0] hit_idx_ff, hit_idx_in;
   entry_type        hit_rec_ff, hit_rec_in;
   logic             free_found_ff, free_found_in;
   logic [IDX_W-1:0] free_idx_ff, free_idx_in;
   logic [31:0]      free_stamp_ff, free_stamp_in;
   rsp_type          rsp_ff, rsp_in;
   logic             rsp_strobe_ff, rsp_strobe_in;

   entry_type rec;
   entry_type new_rec;
   logic      accept;
   logic      in_range;
   logic      tag_match;
   logic      free_better;

   // Entry currently on the read port; never-written entries read as zero.
   assign rec       = valid_ff[cnt_ff] ? entry_type'(mem_rdata) : '0;
   assign accept    = start && (state_ff == ST_IDLE);
   assign in_range  = 32'(req_data.entry_index) < ENTRIES;
   assign tag_match = rec.in_use && (rec.device == req_ff.device_number) &&
                      (rec.block == req_ff.block_number);
   assign free_better = (rec.ref_count == '0) &&
                        (!free_found_ff || (rec.stamp < free_stamp_ff));

   // State and control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         valid_ff      <= '0;
         hit_found_ff  <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         hit_found_ff  <= hit_found_in;
         free_found_ff <= free_found_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      cnt_ff        <= cnt_in;
      req_ff        <= req_in;
      hit_idx_ff    <= hit_idx_in;
      hit_rec_ff    <= hit_rec_in;
      free_idx_ff   <= free_idx_in;
      free_stamp_ff <= free_stamp_in;
      rsp_ff        <= rsp_in;
   end

   // Next state, memory accesses and the response. Reads happen only on
   // accept and during the scan, writes only in the final state, so the
   // sequencer itself keeps accesses to one entry from overlapping.
   always_comb begin
      state_in      = state_ff;
      cnt_in        = cnt_ff;
      req_in        = req_ff;
      valid_in      = valid_ff;
      hit_found_in  = hit_found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_rec_in    = hit_rec_ff;
      free_found_in = free_found_ff;
      free_idx_in   = free_idx_ff;
      free_stamp_in = free_stamp_ff;
      rsp_in        = rsp_ff;
      rsp_strobe_in = 1'b0;
      mem_we        = 1'b0;
      mem_waddr     = cnt_ff;
      mem_wdata     = '0;
      mem_re        = 1'b0;
      mem_raddr     = '0;
      new_rec       = rec;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in        = req_data;
               hit_found_in  = 1'b0;
               free_found_in = 1'b0;
               if (req_data.command == CMD_GET) begin
                  mem_re   = 1'b1;
                  mem_raddr = '0;
                  cnt_in   = '0;
                  state_in = ST_SCAN;
               end else if (in_range) begin
                  mem_re    = 1'b1;
                  mem_raddr = IDX_W'(req_data.entry_index);
                  cnt_in    = IDX_W'(req_data.entry_index);
                  state_in  = ST_EXAM;
               end else begin
                  // Entry beyond the directory: ignored, reported as done.
                  rsp_in        = '{status: STAT_DONE, hit: 1'b0,
                                    found_entry: '0, need_read: 1'b0};
                  rsp_strobe_in = 1'b1;
               end
            end
         end

         ST_SCAN: begin
            // First tag match wins; the free pick keeps the oldest stamp.
            if (tag_match && !hit_found_ff) begin
               hit_found_in = 1'b1;
               hit_idx_in   = cnt_ff;
               hit_rec_in   = rec;
            end
            if (free_better) begin
               free_found_in = 1'b1;
               free_idx_in   = cnt_ff;
               free_stamp_in = rec.stamp;
            end
            if (cnt_ff == LAST_IDX) begin
               state_in = ST_WRITE;
            end else begin
               mem_re    = 1'b1;
               mem_raddr = cnt_ff + 1'b1;
               cnt_in    = cnt_ff + 1'b1;
            end
         end

         ST_WRITE: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            if (hit_found_ff) begin
               new_rec            = hit_rec_ff;
               new_rec.ref_count  = hit_rec_ff.ref_count + 1'b1;
               new_rec.data_valid = 1'b1;
               mem_waddr          = hit_idx_ff;
               mem_wdata          = new_rec;
               if (hit_rec_ff.ref_count == COUNT_MAX) begin
                  rsp_in = '{status: STAT_COUNT_ERR, hit: 1'b1,
                             found_entry: 5'(hit_idx_ff), need_read: 1'b0};
               end else begin
                  mem_we               = 1'b1;
                  valid_in[hit_idx_ff] = 1'b1;
                  rsp_in = '{status: STAT_DONE, hit: 1'b1,
                             found_entry: 5'(hit_idx_ff),
                             need_read: !hit_rec_ff.data_valid};
               end
            end else if (free_found_ff) begin
               // Retag the chosen entry; its release stamp is kept.
               new_rec = '{in_use: 1'b1, device: req_ff.device_number,
                           block: req_ff.block_number, data_valid: 1'b1,
                           ref_count: COUNT_W'(1), stamp: free_stamp_ff};
               mem_we                = 1'b1;
               mem_waddr             = free_idx_ff;
               mem_wdata             = new_rec;
               valid_in[free_idx_ff] = 1'b1;
               rsp_in = '{status: STAT_DONE, hit: 1'b0,
                          found_entry: 5'(free_idx_ff), need_read: 1'b1};
            end else begin
               rsp_in = '{status: STAT_NO_FREE, hit: 1'b0,
                          found_entry: '0, need_read: 1'b0};
            end
         end

         ST_EXAM: begin
            state_in      = ST_IDLE;
            rsp_strobe_in = 1'b1;
            rsp_in        = '{status: STAT_DONE, hit: 1'b0,
                              found_entry: '0, need_read: 1'b0};
            if (req_ff.command == CMD_PIN) begin
               if (rec.ref_count == COUNT_MAX) begin
                  rsp_in.status = STAT_COUNT_ERR;
               end else begin
                  new_rec.ref_count = rec.ref_count + 1'b1;
                  mem_we            = 1'b1;
               end
            end else begin
               if (rec.ref_count == '0) begin
                  rsp_in.status = STAT_COUNT_ERR;
               end else begin
                  new_rec.ref_count = rec.ref_count - 1'b1;
                  // Only a release that drops the last reference stamps.
                  if ((req_ff.command == CMD_RELEASE) &&
                      (rec.ref_count == COUNT_W'(1))) begin
                     new_rec.stamp = req_ff.time_now;
                  end
                  mem_we = 1'b1;
               end
            end
            mem_wdata = new_rec;
            if (mem_we) begin
               valid_in[cnt_ff] = 1'b1;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy       = (state_ff != ST_IDLE);
   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // A read and a write of the directory never share a cycle.
   a_no_rw_overlap: assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re))
      else $error("directory read and write in the same cycle");

   // The scan walks the entries one per cycle.
   a_scan_step: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && cnt_ff != LAST_IDX) |=>
         (state_ff == ST_SCAN && cnt_ff == $past(cnt_ff) + 1'b1))
      else $error("scan did not advance by one entry");

   // The last scanned entry leads to the write-back and then a response.
   a_scan_end: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN && cnt_ff == LAST_IDX) |=>
         (state_ff == ST_WRITE) ##1 rsp_strobe)
      else $error("scan end not followed by write-back and response");

   // A hit is never reported together with a missing free entry.
   a_hit_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_data.hit) |-> (rsp_data.status != STAT_NO_FREE))
      else $error("hit reported with no-free status");

endmodule

`default_nettype wire

// File: bench/bbcd_checker.sv
// ----------------------------------------------------------------------------
// bbcd_checker
// Watches the request and response channels of the buffer cache directory.
// It keeps its own copy of the directory, works out the response of every
// accepted request item and compares each strobed response with it.
// ----------------------------------------------------------------------------

module bbcd_checker
   import bbcd_pkg::*;
#(
   parameter int unsigned ENTRIES = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_strobe,
   input  rsp_type rsp_data,
   output int      failures,
   output int      pending
);

   // Shadow copy of the directory.
   logic               dir_tagged [ENTRIES];
   logic [7:0]         dir_device [ENTRIES];
   logic [31:0]        dir_block  [ENTRIES];
   logic               dir_valid  [ENTRIES];
   logic [COUNT_W-1:0] dir_refs   [ENTRIES];
   logic [31:0]        dir_stamp  [ENTRIES];

   // Responses still owed by the block, oldest first.
   rsp_type owed_rsp_q [$];

   initial failures = 0;

   // Clear the shadow directory to its state after reset.
   task automatic clear_directory();
      for (int i = 0; i < ENTRIES; i++) begin
         dir_tagged[i] = 1'b0;
         dir_device[i] = '0;
         dir_block[i]  = '0;
         dir_valid[i]  = 1'b0;
         dir_refs[i]   = '0;
         dir_stamp[i]  = '0;
      end
   endtask

   // Apply one request item to the shadow directory and return its response.
   task automatic apply_request(input req_type r, output rsp_type o);
      int hit_at;
      int pick;
      hit_at = -1;
      pick = -1;
      o = '0;
      o.status = STAT_DONE;
      if (r.command == CMD_GET) begin
         // Released entries stay tagged and can still be found.
         for (int i = 0; i < ENTRIES; i++) begin
            if (hit_at < 0 && dir_tagged[i] && dir_device[i] == r.device_number &&
                dir_block[i] == r.block_number)
               hit_at = i;
         end
         if (hit_at >= 0) begin
            o.hit = 1'b1;
            o.found_entry = 5'(hit_at);
            if (dir_refs[hit_at] == COUNT_MAX) begin
               o.status = STAT_COUNT_ERR;
            end else begin
               dir_refs[hit_at] = dir_refs[hit_at] + 1'b1;
               o.need_read = !dir_valid[hit_at];
               dir_valid[hit_at] = 1'b1;
            end
         end else begin
            // Oldest release among unreferenced entries, lowest index on a tie.
            for (int i = 0; i < ENTRIES; i++) begin
               if (dir_refs[i] == '0 && (pick < 0 || dir_stamp[i] < dir_stamp[pick]))
                  pick = i;
            end
            if (pick < 0) begin
               o.status = STAT_NO_FREE;
            end else begin
               dir_tagged[pick] = 1'b1;
               dir_device[pick] = r.device_number;
               dir_block[pick]  = r.block_number;
               dir_refs[pick]   = COUNT_W'(1);
               dir_valid[pick]  = 1'b1;
               o.found_entry = 5'(pick);
               o.need_read = 1'b1;
            end
         end
      end else if (r.entry_index < ENTRIES) begin
         if (r.command == CMD_PIN) begin
            if (dir_refs[r.entry_index] == COUNT_MAX)
               o.status = STAT_COUNT_ERR;
            else
               dir_refs[r.entry_index] = dir_refs[r.entry_index] + 1'b1;
         end else if (dir_refs[r.entry_index] == '0) begin
            o.status = STAT_COUNT_ERR;
         end else begin
            dir_refs[r.entry_index] = dir_refs[r.entry_index] - 1'b1;
            // Only a release that drops the last reference stamps the time.
            if (r.command == CMD_RELEASE && dir_refs[r.entry_index] == '0)
               dir_stamp[r.entry_index] = r.time_now;
         end
      end
   endtask

   task automatic report_field(input string field, input logic [7:0] want,
                               input logic [7:0] got);
      if (got !== want) begin
         failures++;
         $display("%0t: response %s mismatch, expected %0h, actual %0h",
                  $time, field, want, got);
      end
   endtask

   // Check each strobed response, then predict the response of an accepted item.
   always @(posedge clock) begin
      rsp_type want;
      rsp_type next_rsp;
      if (reset) begin
         clear_directory();
         owed_rsp_q.delete();
         pending <= 0;
      end else begin
         if (rsp_strobe) begin
            if (owed_rsp_q.size() == 0) begin
               failures++;
               $display("%0t: response with none expected, expected nothing, actual %h",
                        $time, rsp_data);
            end else begin
               want = owed_rsp_q.pop_front();
               report_field("status", 8'(want.status), 8'(rsp_data.status));
               report_field("hit", 8'(want.hit), 8'(rsp_data.hit));
               report_field("found_entry", 8'(want.found_entry), 8'(rsp_data.found_entry));
               report_field("need_read", 8'(want.need_read), 8'(rsp_data.need_read));
            end
         end
         if (start && !busy) begin
            apply_request(req_data, next_rsp);
            owed_rsp_q.push_back(next_rsp);
         end
         pending <= owed_rsp_q.size();
      end
   end

endmodule

// File: bench/tb_block_buffer_cache_directory.sv
// ----------------------------------------------------------------------------
// tb_block_buffer_cache_directory
// Drives the buffer cache directory with directed and random request items.
// A directed part covers each command, field extremes and the corner cases;
// a fill phase exhausts the directory, a saturation phase drives one count to
// its limit, and a random part mixes gets with releases, pins and unpins.
// The checker beside the block predicts and compares every response.
// ----------------------------------------------------------------------------

module tb_block_buffer_cache_directory;
   import bbcd_pkg::*;

   localparam int unsigned ENTRIES = 32;
   localparam int RANDOM_ITEMS = 60;
   localparam int CYCLE_LIMIT = 500000;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_strobe;
   rsp_type rsp_data;
   int      failures;
   int      pending;

   // Stimulus bookkeeping.
   int          cycle_count = 0;
   int          items_sent = 0;
   int          hits = 0;
   int          misses = 0;
   int          full_count = 0;
   int          count_errors = 0;
   bit          gapless = 1'b0;
   logic [31:0] tick = 0;
   cmd_type     last_cmd = CMD_GET;
   logic [4:0]  last_found = '0;
   logic [4:0]  held_q [$];

   block_buffer_cache_directory #(.ENTRIES(ENTRIES)) uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   bbcd_checker #(.ENTRIES(ENTRIES)) u_checker (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .failures   (failures),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Give up on a hung block.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Track entries handed out by gets so that later releases name them.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_strobe) begin
            last_found <= rsp_data.found_entry;
            if (last_cmd == CMD_GET && rsp_data.status == STAT_DONE) begin
               if (rsp_data.hit)
                  hits++;
               else
                  misses++;
               held_q.push_back(rsp_data.found_entry);
            end
            if (rsp_data.status == STAT_NO_FREE)
               full_count++;
            if (rsp_data.status == STAT_COUNT_ERR)
               count_errors++;
         end
         if (start && !busy)
            last_cmd <= req_data.command;
      end
   end

   function automatic req_type make_req(cmd_type c, logic [7:0] d, logic [31:0] b,
                                        logic [4:0] e, logic [31:0] t);
      req_type r;
      r.command = c;
      r.device_number = d;
      r.block_number = b;
      r.entry_index = e;
      r.time_now = t;
      return r;
   endfunction

   // Mostly back to back, sometimes a short pause, now and then a long one.
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (gapless || roll < 65)
         return 0;
      else if (roll < 93)
         return $urandom_range(1, 3);
      else
         return $urandom_range(8, 40);
   endfunction

   // Offer one item and hold it until the block takes it.
   task automatic issue(input req_type r);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (busy);
      items_sent++;
   endtask

   // Hold off until every response owed has come back.
   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // One random item, with releases and unpins mostly naming held entries.
   task automatic random_item();
      int roll;
      int k;
      logic [7:0] dev;
      logic [31:0] blk;
      logic [4:0] idx;
      logic [31:0] stamp;
      roll = $urandom_range(0, 99);
      dev = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
      blk = ($urandom_range(0, 4) == 0) ? $urandom : 32'($urandom_range(0, 23));
      tick = tick + $urandom_range(0, 50);
      stamp = ($urandom_range(0, 9) == 0) ? $urandom : tick;
      idx = 5'($urandom_range(0, ENTRIES - 1));
      if (held_q.size() != 0 && $urandom_range(0, 3) != 0) begin
         k = $urandom_range(0, held_q.size() - 1);
         idx = held_q[k];
         if (roll >= 40 && roll < 70 || roll >= 82)
            held_q.delete(k);
      end
      if (roll < 40) begin
         issue(make_req(CMD_GET, dev, blk, idx, stamp));
      end else if (roll < 70) begin
         issue(make_req(CMD_RELEASE, dev, blk, idx, stamp));
      end else if (roll < 82) begin
         held_q.push_back(idx);
         issue(make_req(CMD_PIN, dev, blk, idx, stamp));
      end else begin
         issue(make_req(CMD_UNPIN, dev, blk, idx, stamp));
      end
   endtask

   initial begin
      logic [4:0] hot;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed: commands, field extremes and the corner cases.
      issue(make_req(CMD_GET, 8'h00, 32'h0000_0000, 5'd0, 32'd0));
      issue(make_req(CMD_GET, 8'h00, 32'h0000_0000, 5'd31, 32'd0));
      issue(make_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'hFFFF_FFFF));
      issue(make_req(CMD_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'd0));
      issue(make_req(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'd5));
      issue(make_req(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'd9));
      issue(make_req(CMD_UNPIN, 8'h00, 32'h0000_0000, 5'd2, 32'd0));
      issue(make_req(CMD_PIN, 8'h00, 32'h0000_0000, 5'd2, 32'd0));
      issue(make_req(CMD_UNPIN, 8'h00, 32'h0000_0000, 5'd2, 32'hFFFF_FFFF));
      issue(make_req(CMD_GET, 8'h00, 32'h0000_0000, 5'd0, 32'd0));
      issue(make_req(CMD_GET, 8'h01, 32'h0000_0001, 5'd0, 32'd0));
      issue(make_req(CMD_RELEASE, 8'hFF, 32'hFFFF_FFFF, 5'd1, 32'hFFFF_FFFF));
      issue(make_req(CMD_PIN, 8'hFF, 32'hFFFF_FFFF, 5'd31, 32'hFFFF_FFFF));
      issue(make_req(CMD_UNPIN, 8'h00, 32'h0000_0000, 5'd31, 32'd0));
      issue(make_req(CMD_RELEASE, 8'h00, 32'h0000_0000, 5'd0, 32'd7));
      issue(make_req(CMD_RELEASE, 8'h01, 32'h0000_0001, 5'd2, 32'd3));
      issue(make_req(CMD_GET, 8'hFF, 32'hFFFF_FFFF, 5'd0, 32'd0));
      issue(make_req(CMD_GET, 8'h01, 32'h0000_0001, 5'd0, 32'd0));
      issue(make_req(CMD_GET, 8'h80, 32'h8000_0000, 5'd16, 32'h8000_0000));
      wait_drained();

      // Fill: distinct blocks until no entry is left, then release them all.
      for (int i = 0; i < ENTRIES + 3; i++)
         issue(make_req(CMD_GET, 8'hA5, 32'h0001_0000 + i, 5'd0, tick));
      for (int i = 0; i < ENTRIES; i++)
         issue(make_req(CMD_RELEASE, 8'h00, 32'h0, 5'(i), $urandom));
      wait_drained();
      held_q.delete();

      // Saturation: drive one entry's count to its limit and past it.
      issue(make_req(CMD_GET, 8'h3C, 32'hDEAD_BEEF, 5'd0, 32'd0));
      wait_drained();
      hot = last_found;
      gapless = 1'b1;
      for (int i = 0; i < 255; i++)
         issue(make_req(CMD_PIN, 8'h00, 32'h0, hot, 32'd0));
      issue(make_req(CMD_GET, 8'h3C, 32'hDEAD_BEEF, 5'd0, 32'd0));
      issue(make_req(CMD_UNPIN, 8'h00, 32'h0, hot, 32'd0));
      gapless = 1'b0;
      wait_drained();
      held_q.delete();

      // Random: gets over a small set of blocks mixed with count updates.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         gapless = ((n / 20) % 3) == 2;
         random_item();
      end

      wait_drained();
      repeat (ENTRIES + 8) @(posedge clock);
      $display("Sent %0d items: %0d get hits, %0d get misses, %0d directory full,",
               items_sent, hits, misses, full_count);
      $display("%0d count overflow or underflow responses.", count_errors);
      if (failures == 0 && pending == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
